### src/pfde_pkg.sv
package pfde_pkg;

  localparam int unsigned LetterW   = 5;
  localparam int unsigned SquareDim = 5;
  localparam int unsigned RowW      = LetterW * SquareDim;
  localparam int unsigned IdxW      = $clog2(SquareDim);
  localparam int unsigned CfgIdxW   = 3;

  typedef logic [LetterW-1:0] letter_t;
  typedef logic [RowW-1:0]    sq_row_t;
  typedef logic [IdxW-1:0]    sq_idx_t;

  // Letter codes, a is zero
  localparam letter_t LetterI = letter_t'(8);
  localparam letter_t LetterJ = letter_t'(9);
  localparam letter_t LetterX = letter_t'(23);
  localparam letter_t LetterZ = letter_t'(25);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgSquareRow0 = 3'd0,
    CfgSquareRow1 = 3'd1,
    CfgSquareRow2 = 3'd2,
    CfgSquareRow3 = 3'd3,
    CfgSquareRow4 = 3'd4
  } cfg_reg_e;

  // Reset square: a..z without j, row by row
  localparam sq_row_t SquareRow0Rst = sq_row_t'(4294688);
  localparam sq_row_t SquareRow1Rst = sq_row_t'(10755269);
  localparam sq_row_t SquareRow2Rst = sq_row_t'(16201099);
  localparam sq_row_t SquareRow3Rst = sq_row_t'(21613104);
  localparam sq_row_t SquareRow4Rst = sq_row_t'(27025109);

  typedef struct packed {
    sq_idx_t row;
    sq_idx_t col;
  } sq_pos_t;

endpackage

### src/pfde_ifs.sv
interface pfde_plain_if;
  logic                       valid;
  logic                       ready;
  logic [pfde_pkg::LetterW-1:0] plain_letter;
  logic                       message_end;

  modport source (output valid, output plain_letter, output message_end, input ready);
  modport sink   (input valid, input plain_letter, input message_end, output ready);
endinterface

interface pfde_cipher_if;
  logic                       valid;
  logic                       ready;
  logic [pfde_pkg::LetterW-1:0] cipher_letter;
  logic                       run_last;
  logic                       message_done;

  modport source (output valid, output cipher_letter, output run_last,
                  output message_done, input ready);
  modport sink   (input valid, input cipher_letter, input run_last,
                  input message_done, output ready);
endinterface

### src/playfair_digraph_encrypt_core.sv
// Channel    Direction  Payload                                      Handshake
// plain_i    in         plain_letter[4:0], message_end               valid/ready
// cipher_o   out        cipher_letter[4:0], run_last, message_done   valid/ready
// cfg        in         cfg_idx_i[2:0], cfg_wdata_i[24:0]            cfg_we_i only
//
// A letter that only opens a pair is taken and gives nothing.
// A letter that closes a digraph is encrypted in the cycle it is accepted and
// its two cipher letters leave one by one from the result register; a repeat
// at message end gives the same padded digraph twice, four letters. The
// result register and its letter counter pace the input: the next letter is
// taken in the cycle the last letter of a transaction leaves. Reset (rst_ni
// low, asynchronous) empties the result register, drops any open pair and
// loads the alphabetical square. A stall on cipher_o holds the result;
// plain_i is back-pressured until the last letter of the result leaves.
module playfair_digraph_encrypt_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pfde_plain_if.sink                    plain_i,
  pfde_cipher_if.source                 cipher_o,
  input  logic                          cfg_we_i,
  input  logic [pfde_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pfde_pkg::RowW-1:0]     cfg_wdata_i
);

  // Square storage
  pfde_pkg::sq_row_t sq_q [pfde_pkg::SquareDim];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q[0] <= pfde_pkg::SquareRow0Rst;
      sq_q[1] <= pfde_pkg::SquareRow1Rst;
      sq_q[2] <= pfde_pkg::SquareRow2Rst;
      sq_q[3] <= pfde_pkg::SquareRow3Rst;
      sq_q[4] <= pfde_pkg::SquareRow4Rst;
    end else if (cfg_we_i && (cfg_idx_i <= pfde_pkg::CfgSquareRow4)) begin
      // writes beyond the last row are dropped
      sq_q[cfg_idx_i[pfde_pkg::IdxW-1:0]] <= cfg_wdata_i;
    end
  end

  // Find a letter in the square; the last match in row-major order wins,
  // no match lands on the top-left corner.
  function automatic pfde_pkg::sq_pos_t locate(input pfde_pkg::letter_t ltr,
                                               input pfde_pkg::sq_row_t sq [pfde_pkg::SquareDim]);
    pfde_pkg::sq_pos_t p;
    p = '0;
    for (int r = 0; r < pfde_pkg::SquareDim; r++) begin
      for (int c = 0; c < pfde_pkg::SquareDim; c++) begin
        if (sq[r][c*pfde_pkg::LetterW +: pfde_pkg::LetterW] == ltr) begin
          p.row = pfde_pkg::IdxW'(r);
          p.col = pfde_pkg::IdxW'(c);
        end
      end
    end
    return p;
  endfunction

  function automatic pfde_pkg::sq_idx_t wrap_next(input pfde_pkg::sq_idx_t i);
    return (i == pfde_pkg::IdxW'(pfde_pkg::SquareDim - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic pfde_pkg::letter_t pad_for(input pfde_pkg::letter_t ltr);
    return (ltr == pfde_pkg::LetterX) ? pfde_pkg::LetterZ : pfde_pkg::LetterX;
  endfunction

  // Open pair
  logic              pend_vld_q, pend_vld_d;
  pfde_pkg::letter_t pend_ltr_q, pend_ltr_d;

  // Result register: one digraph, replayed once for a repeat at message end
  logic              res_vld_q;
  pfde_pkg::letter_t res_e1_q, res_e2_q;
  logic              res_rep_q, res_done_q;
  logic [1:0]        res_pos_q;
  logic              res_at_last;

  logic in_acc, out_acc;
  pfde_pkg::letter_t ltr, pa, pb;
  logic emit, rep, done;

  assign res_at_last = (res_pos_q == (res_rep_q ? 2'd3 : 2'd1));
  assign out_acc     = cipher_o.valid && cipher_o.ready;
  // Take a new letter once the result register is empty or its last letter leaves
  assign plain_i.ready = !res_vld_q || (out_acc && res_at_last);
  assign in_acc        = plain_i.valid && plain_i.ready;

  // Pair formation
  always_comb begin
    ltr = plain_i.plain_letter;
    if (ltr == pfde_pkg::LetterJ) begin
      ltr = pfde_pkg::LetterI;
    end
    pend_vld_d = pend_vld_q;
    pend_ltr_d = pend_ltr_q;
    pa   = pend_ltr_q;
    pb   = ltr;
    emit = 1'b1;
    rep  = 1'b0;
    done = plain_i.message_end;
    if (!pend_vld_q) begin
      pa = ltr;
      pb = pad_for(ltr);
      if (!plain_i.message_end) begin
        // hold the letter until its partner arrives
        emit       = 1'b0;
        pend_vld_d = 1'b1;
        pend_ltr_d = ltr;
      end
    end else if (pend_ltr_q != ltr) begin
      pend_vld_d = 1'b0;
    end else begin
      // repeated letter: pad the open pair; the repeat opens the next one, or at message end the digraph is replayed
      pb = pad_for(pend_ltr_q);
      if (plain_i.message_end) begin
        rep        = 1'b1;
        pend_vld_d = 1'b0;
      end
    end
  end

  // Digraph encryption
  pfde_pkg::sq_pos_t p1, p2;
  pfde_pkg::sq_idx_t r1, c1, r2, c2;
  pfde_pkg::letter_t e1, e2;

  always_comb begin
    p1 = locate(pa, sq_q);
    p2 = locate(pb, sq_q);
    r1 = p1.row;
    c1 = p1.col;
    r2 = p2.row;
    c2 = p2.col;
    if (p1.row == p2.row) begin
      c1 = wrap_next(p1.col);
      c2 = wrap_next(p2.col);
    end else if (p1.col == p2.col) begin
      r1 = wrap_next(p1.row);
      r2 = wrap_next(p2.row);
    end else begin
      c1 = p2.col;
      c2 = p1.col;
    end
    e1 = sq_q[r1][5'(c1) * 5'(pfde_pkg::LetterW) +: pfde_pkg::LetterW];
    e2 = sq_q[r2][5'(c2) * 5'(pfde_pkg::LetterW) +: pfde_pkg::LetterW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      pend_ltr_q <= '0;
    end else if (in_acc) begin
      pend_vld_q <= pend_vld_d;
      pend_ltr_q <= pend_ltr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
      res_pos_q <= '0;
    end else if (in_acc) begin
      // a fresh digraph replaces the finished one, or the register empties
      res_vld_q <= emit;
      res_pos_q <= '0;
    end else if (out_acc) begin
      if (res_at_last) begin
        res_vld_q <= 1'b0;
      end else begin
        res_pos_q <= res_pos_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      res_e1_q   <= e1;
      res_e2_q   <= e2;
      res_rep_q  <= rep;
      res_done_q <= done;
    end
  end

  assign cipher_o.valid         = res_vld_q;
  assign cipher_o.cipher_letter = res_pos_q[0] ? res_e2_q : res_e1_q;
  assign cipher_o.run_last      = res_at_last;
  assign cipher_o.message_done  = res_at_last && res_done_q;

endmodule

### src/pfde_checker.sv
module pfde_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [pfde_pkg::LetterW-1:0] out_letter_i,
  input logic                         out_run_last_i,
  input logic                         out_done_i
);

  // A stalled result holds its letter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_letter_i))
    else $error("cipher letter changed under stall");

  // A transaction that is not finished continues in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_run_last_i |=> out_valid_i)
    else $error("result run broken off");

  // The end of a message always closes its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_done_i |-> out_run_last_i)
    else $error("message done before run end");

  // Input back-pressure comes only from a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result pending");

endmodule

bind playfair_digraph_encrypt_core pfde_checker u_pfde_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (plain_i.ready),
  .out_valid_i    (cipher_o.valid),
  .out_ready_i    (cipher_o.ready),
  .out_letter_i   (cipher_o.cipher_letter),
  .out_run_last_i (cipher_o.run_last),
  .out_done_i     (cipher_o.message_done)
);

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int CyclePeriod = 20;
  localparam int CycleLimit  = 400000;
  localparam int SettleCycles = 8;

  // One plaintext transaction as the sender queues it
  typedef struct packed {
    pfde_pkg::letter_t letter;
    logic              msg_end;
  } plain_item_t;

  // One ciphertext transaction as the encryptor should produce it
  typedef struct packed {
    pfde_pkg::letter_t letter;
    logic              run_last;
    logic              msg_done;
  } cipher_item_t;

  typedef pfde_pkg::sq_row_t square_t [pfde_pkg::SquareDim];

  // Kinds of key square loaded between phases
  typedef enum {
    SqShuffled,
    SqDuplicates,
    SqZeros,
    SqOnes,
    SqRaw,
    SqAlphabet
  } sq_kind_e;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [pfde_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [pfde_pkg::RowW-1:0] cfg_wdata_i;

  pfde_plain_if  plain_if ();
  pfde_cipher_if cipher_if ();

  playfair_digraph_encrypt_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .plain_i    (plain_if),
    .cipher_o   (cipher_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Letters waiting to be offered, and cipher letters owed by the block
  plain_item_t  plain_backlog[$];
  cipher_item_t cipher_due[$];

  // Shadow of the encryptor: the key square and the open half of a digraph
  square_t           key_square;
  pfde_pkg::letter_t open_letter;
  logic              open_valid;

  // Idling: percentage chance of starting a burst, remaining cycles of it
  int feed_pct, take_pct;
  int gap_left, stall_left;

  int mismatches;
  int letters_sent, messages_sent, letters_checked, squares_loaded;
  int cycle_count;

  always #(CyclePeriod / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow encryptor
  // ---------------------------------------------------------------------------

  function automatic pfde_pkg::letter_t sq_cell(int r, int c);
    return key_square[r % pfde_pkg::SquareDim]
                     [pfde_pkg::LetterW*(c % pfde_pkg::SquareDim) +: pfde_pkg::LetterW];
  endfunction

  // Scan the whole square; the last hit in row-major order wins, and a letter
  // absent from the square sits at the top-left corner.
  function automatic pfde_pkg::sq_pos_t find_letter(pfde_pkg::letter_t l);
    pfde_pkg::sq_pos_t p;
    p = '0;
    for (int r = 0; r < pfde_pkg::SquareDim; r++)
      for (int c = 0; c < pfde_pkg::SquareDim; c++)
        if (sq_cell(r, c) == l) begin
          p.row = pfde_pkg::sq_idx_t'(r);
          p.col = pfde_pkg::sq_idx_t'(c);
        end
    return p;
  endfunction

  function automatic pfde_pkg::letter_t pad_for(pfde_pkg::letter_t l);
    return (l == pfde_pkg::LetterX) ? pfde_pkg::LetterZ : pfde_pkg::LetterX;
  endfunction

  // Encrypt one digraph and owe its two cipher letters
  function automatic void owe_digraph(pfde_pkg::letter_t a, pfde_pkg::letter_t b,
                                      logic run_last, logic msg_done);
    pfde_pkg::sq_pos_t pa, pb;
    cipher_item_t ca, cb;
    pa = find_letter(a);
    pb = find_letter(b);
    if (pa.row == pb.row) begin
      ca.letter = sq_cell(int'(pa.row), int'(pa.col) + 1);
      cb.letter = sq_cell(int'(pb.row), int'(pb.col) + 1);
    end else if (pa.col == pb.col) begin
      ca.letter = sq_cell(int'(pa.row) + 1, int'(pa.col));
      cb.letter = sq_cell(int'(pb.row) + 1, int'(pb.col));
    end else begin
      ca.letter = sq_cell(int'(pa.row), int'(pb.col));
      cb.letter = sq_cell(int'(pb.row), int'(pa.col));
    end
    ca.run_last = 1'b0;
    ca.msg_done = 1'b0;
    cb.run_last = run_last;
    cb.msg_done = msg_done;
    cipher_due = {cipher_due, ca};
    cipher_due = {cipher_due, cb};
  endfunction

  // Advance the shadow by one accepted plaintext letter
  function automatic void encrypt_letter(pfde_pkg::letter_t l, logic msg_end);
    if (l == pfde_pkg::LetterJ) l = pfde_pkg::LetterI;
    if (!open_valid) begin
      if (!msg_end) begin
        open_letter = l;
        open_valid  = 1'b1;
      end else begin
        owe_digraph(l, pad_for(l), 1'b1, 1'b1);
      end
    end else if (open_letter != l) begin
      open_valid = 1'b0;
      owe_digraph(open_letter, l, 1'b1, msg_end);
    end else if (!msg_end) begin
      // Repeat: close the open pair with a pad, the repeat stays open
      owe_digraph(l, pad_for(l), 1'b1, 1'b0);
    end else begin
      // Repeat on the last letter: two padded digraphs, four letters
      owe_digraph(l, pad_for(l), 1'b0, 1'b0);
      owe_digraph(l, pad_for(l), 1'b1, 1'b1);
      open_valid = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void queue_letter(pfde_pkg::letter_t l, logic msg_end);
    plain_item_t it;
    it.letter  = l;
    it.msg_end = msg_end;
    plain_backlog = {plain_backlog, it};
  endfunction

  // Favour repeats, j, codes off the alphabet and codes held by the square
  function automatic pfde_pkg::letter_t pick_letter(pfde_pkg::letter_t prev, bit has_prev);
    int r;
    r = $urandom_range(0, 99);
    if (has_prev && r < 18) return prev;
    if (r < 24) return pfde_pkg::letter_t'($urandom_range(26, 31));
    if (r < 30) return pfde_pkg::LetterJ;
    if (r < 50) return sq_cell($urandom_range(0, pfde_pkg::SquareDim-1),
                               $urandom_range(0, pfde_pkg::SquareDim-1));
    return pfde_pkg::letter_t'($urandom_range(0, 25));
  endfunction

  function automatic square_t make_square(sq_kind_e kind);
    square_t rows;
    pfde_pkg::letter_t pool [pfde_pkg::SquareDim*pfde_pkg::SquareDim];
    pfde_pkg::letter_t tmp;
    int n, k;
    n = 0;
    for (int l = 0; l < 26; l++)
      if (pfde_pkg::letter_t'(l) != pfde_pkg::LetterJ) begin
        pool[n] = pfde_pkg::letter_t'(l);
        n++;
      end
    for (int i = pfde_pkg::SquareDim*pfde_pkg::SquareDim - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      tmp = pool[i];
      pool[i] = pool[k];
      pool[k] = tmp;
    end
    if (kind == SqDuplicates)
      for (int i = 0; i < 4; i++)
        pool[$urandom_range(0, pfde_pkg::SquareDim*pfde_pkg::SquareDim - 1)] =
          ($urandom_range(0, 1) != 0)
            ? pool[$urandom_range(0, pfde_pkg::SquareDim*pfde_pkg::SquareDim - 1)]
            : pfde_pkg::letter_t'($urandom_range(0, 31));
    for (int r = 0; r < pfde_pkg::SquareDim; r++)
      for (int c = 0; c < pfde_pkg::SquareDim; c++)
        rows[r][pfde_pkg::LetterW*c +: pfde_pkg::LetterW] = pool[pfde_pkg::SquareDim*r + c];
    case (kind)
      SqZeros: rows = '{default: '0};
      SqOnes:  rows = '{default: '1};
      SqRaw: begin
        for (int r = 0; r < pfde_pkg::SquareDim; r++)
          rows[r] = pfde_pkg::sq_row_t'($urandom_range(0, 33554431));
      end
      SqAlphabet: rows = '{pfde_pkg::SquareRow0Rst, pfde_pkg::SquareRow1Rst,
                           pfde_pkg::SquareRow2Rst, pfde_pkg::SquareRow3Rst,
                           pfde_pkg::SquareRow4Rst};
      default: ;
    endcase
    return rows;
  endfunction

  // Write every square row; the block is idle whenever this runs
  task automatic load_square(input square_t rows);
    for (int i = 0; i < pfde_pkg::SquareDim; i++) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= pfde_pkg::cfg_reg_e'(i);
      cfg_wdata_i <= rows[i];
      key_square[i] = rows[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    squares_loaded++;
  endtask

  // Hold until every letter is taken and every cipher letter has come back,
  // then let a letter still being absorbed settle
  task automatic drain;
    while (plain_backlog.size() > 0 || plain_if.valid || cipher_due.size() > 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(sq_kind_e kind, int n_items, bit calm);
    int msg_len, left;
    pfde_pkg::letter_t prev;
    pfde_pkg::letter_t l;
    feed_pct = calm ? 0 : $urandom_range(0, 35);
    take_pct = calm ? 0 : $urandom_range(0, 35);
    load_square(make_square(kind));
    @(negedge clk_i);
    left = n_items;
    prev = '0;
    while (left > 0) begin
      msg_len = $urandom_range(1, 12);
      if (msg_len > left) msg_len = left;
      for (int k = 0; k < msg_len; k++) begin
        l = pick_letter(prev, k > 0);
        queue_letter(l, k == msg_len - 1);
        prev = l;
      end
      left -= msg_len;
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offer the backlog, hold on back-pressure, idle in bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : letter_feed
    plain_item_t nxt;
    if (!rst_ni) begin
      plain_if.valid <= 1'b0;
    end else begin
      // Predict from the values that the block saw at this edge
      if (plain_if.valid && plain_if.ready) begin
        encrypt_letter(plain_if.plain_letter, plain_if.message_end);
        letters_sent++;
        if (plain_if.message_end) messages_sent++;
      end
      if (!plain_if.valid || plain_if.ready) begin
        if (gap_left == 0 && feed_pct > 0 && $urandom_range(0, 99) < feed_pct)
          gap_left = $urandom_range(1, 16);
        if (gap_left > 0) begin
          gap_left--;
          plain_if.valid <= 1'b0;
        end else if (plain_backlog.size() > 0) begin
          nxt = plain_backlog.pop_front();
          plain_if.valid        <= 1'b1;
          plain_if.plain_letter <= nxt.letter;
          plain_if.message_end  <= nxt.msg_end;
        end else begin
          plain_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: check each cipher transaction against the oldest owed letter
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : cipher_check
    cipher_item_t want;
    if (!rst_ni) begin
      cipher_if.ready <= 1'b0;
    end else begin
      if (cipher_if.valid && cipher_if.ready) begin
        letters_checked++;
        if (cipher_due.size() == 0) begin
          $display("%0t: unexpected cipher letter %0d run_last %0b message_done %0b",
                   $time, cipher_if.cipher_letter, cipher_if.run_last,
                   cipher_if.message_done);
          mismatches++;
        end else begin
          want = cipher_due.pop_front();
          if (cipher_if.cipher_letter !== want.letter) begin
            $display("%0t: cipher_letter expected %0d actual %0d", $time,
                     want.letter, cipher_if.cipher_letter);
            mismatches++;
          end
          if (cipher_if.run_last !== want.run_last) begin
            $display("%0t: run_last expected %0b actual %0b", $time,
                     want.run_last, cipher_if.run_last);
            mismatches++;
          end
          if (cipher_if.message_done !== want.msg_done) begin
            $display("%0t: message_done expected %0b actual %0b", $time,
                     want.msg_done, cipher_if.message_done);
            mismatches++;
          end
        end
      end
      if (stall_left == 0 && take_pct > 0 && $urandom_range(0, 99) < take_pct)
        stall_left = $urandom_range(1, 16);
      if (stall_left > 0) begin
        stall_left--;
        cipher_if.ready <= 1'b0;
      end else begin
        cipher_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: drop the run if the block stops moving
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    clk_i                 = 1'b0;
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = pfde_pkg::CfgSquareRow0;
    cfg_wdata_i           = '0;
    plain_if.valid        = 1'b0;
    plain_if.plain_letter = '0;
    plain_if.message_end  = 1'b0;
    cipher_if.ready       = 1'b0;
    key_square  = '{pfde_pkg::SquareRow0Rst, pfde_pkg::SquareRow1Rst,
                    pfde_pkg::SquareRow2Rst, pfde_pkg::SquareRow3Rst,
                    pfde_pkg::SquareRow4Rst};
    open_letter = '0;
    open_valid  = 1'b0;
    feed_pct    = 25;
    take_pct    = 25;
    gap_left    = 0;
    stall_left  = 0;
    mismatches  = 0;
    letters_sent    = 0;
    messages_sent   = 0;
    letters_checked = 0;
    squares_loaded  = 0;
    cycle_count     = 0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed letters on the alphabetical square left by reset
    @(negedge clk_i);
    queue_letter(pfde_pkg::letter_t'(0), 1'b0);   // a b: same row
    queue_letter(pfde_pkg::letter_t'(1), 1'b0);
    queue_letter(pfde_pkg::letter_t'(0), 1'b0);   // a f: same column
    queue_letter(pfde_pkg::letter_t'(5), 1'b0);
    queue_letter(pfde_pkg::letter_t'(4), 1'b0);   // e z: same column, wrap to the top
    queue_letter(pfde_pkg::LetterZ, 1'b0);
    queue_letter(pfde_pkg::letter_t'(24), 1'b0);  // y z: same row, wrap to the left
    queue_letter(pfde_pkg::LetterZ, 1'b0);
    queue_letter(pfde_pkg::letter_t'(6), 1'b0);   // g s: rectangle
    queue_letter(pfde_pkg::letter_t'(18), 1'b0);
    queue_letter(pfde_pkg::letter_t'(2), 1'b0);   // c c d: repeat mid-message
    queue_letter(pfde_pkg::letter_t'(2), 1'b0);
    queue_letter(pfde_pkg::letter_t'(3), 1'b1);
    queue_letter(pfde_pkg::LetterX, 1'b0);        // x x at the end: padded with z, twice
    queue_letter(pfde_pkg::LetterX, 1'b1);
    queue_letter(pfde_pkg::LetterZ, 1'b1);        // lone letter ends a message
    queue_letter(pfde_pkg::LetterX, 1'b1);        // lone x takes a z pad
    queue_letter(pfde_pkg::LetterJ, 1'b0);        // j folds onto i: repeat at the end
    queue_letter(pfde_pkg::LetterI, 1'b1);
    queue_letter(pfde_pkg::letter_t'(31), 1'b0);  // codes off the alphabet, not in square
    queue_letter(pfde_pkg::letter_t'(26), 1'b1);
    queue_letter(pfde_pkg::letter_t'(16), 1'b0);  // chain of repeats
    queue_letter(pfde_pkg::letter_t'(16), 1'b0);
    queue_letter(pfde_pkg::letter_t'(16), 1'b1);
    drain();

    // Random messages over a range of squares, extremes included
    run_phase(SqShuffled,   60, 1'b0);
    run_phase(SqZeros,      15, 1'b0);
    run_phase(SqOnes,       15, 1'b0);
    run_phase(SqRaw,        50, 1'b0);
    run_phase(SqDuplicates, 60, 1'b0);
    run_phase(SqAlphabet,   50, 1'b0);
    run_phase(SqShuffled,   60, 1'b0);
    run_phase(SqShuffled,   60, 1'b1);

    $display("Sent %0d letters in %0d messages over %0d loaded squares;",
             letters_sent, messages_sent, squares_loaded);
    $display("checked %0d cipher letters, %0d mismatches.", letters_checked, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
